### hw/rtl/page_table_mapping_installer_defines.svh
// ----------------------------------------------------------------------------
// Page table mapping installer: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_MAPPING_INSTALLER_DEFINES_SVH
`define PAGE_TABLE_MAPPING_INSTALLER_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while in reset.
`define PTMI_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptmi same-cycle check failed");

// Next-cycle implication, sampled on clk and ignored while in reset.
`define PTMI_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptmi next-cycle check failed");

`endif

### hw/rtl/ptmi_pkg.sv
// ----------------------------------------------------------------------------
// Page table mapping installer package
// Shared sizes, codes, item and result types, and the store window check.
// ----------------------------------------------------------------------------
package ptmi_pkg;

    localparam int TABLE_FRAMES      = 64;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int INDEX_BITS        = 9;
    localparam int FRAME_BITS        = $clog2(TABLE_FRAMES);
    localparam int STORE_BITS        = FRAME_BITS + INDEX_BITS;
    localparam int STORE_DEPTH       = TABLE_FRAMES * ENTRIES_PER_TABLE;
    localparam int ADDR_BITS         = 48;
    localparam int PAGE_BITS         = ADDR_BITS - 12;

    // Result status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_FRAMES = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ROOT_TABLE   = 2'd0;
    localparam logic [1:0] REG_FIRST_FREE   = 2'd1;
    localparam logic [1:0] REG_MEMORY_END   = 2'd2;
    localparam logic [1:0] REG_WINDOW_BASE  = 2'd3;

    typedef enum logic [3:0] {
        WK_CLEAR,
        WK_IDLE,
        WK_CHECK,
        WK_READ,
        WK_EVAL,
        WK_LOAD,
        WK_EXHAUST,
        WK_WINDOW,
        WK_ZERO,
        WK_LINK,
        WK_LEAF,
        WK_DONE
    } ptmi_state_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] root_table_address;
        logic [ADDR_BITS-1:0] first_free_frame;
        logic [ADDR_BITS-1:0] memory_end;
        logic [ADDR_BITS-1:0] store_window_base;
    } ptmi_cfg_t;

    typedef struct packed {
        logic [7:0]           flags;
        logic [ADDR_BITS-1:0] physical_address;
        logic [ADDR_BITS-1:0] virtual_address;
    } ptmi_item_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] leaf_entry_value;
        logic [ADDR_BITS-1:0] leaf_entry_address;
        logic [1:0]           tables_created;
        logic [1:0]           status;
    } ptmi_result_t;

    // Handshake between the top level and the walker.
    typedef struct packed {
        logic ready;
        logic done;
    } ptmi_wk_status_t;

    typedef struct packed {
        logic                  ok;
        logic [FRAME_BITS-1:0] frame;
    } ptmi_win_t;

    // Locates a table page inside the store window of TABLE_FRAMES frames.
    function automatic ptmi_win_t window_check(logic [PAGE_BITS-1:0] page,
                                               logic [PAGE_BITS-1:0] base_page);
        ptmi_win_t             r;
        logic [PAGE_BITS-1:0]  diff;
        diff    = page - base_page;
        r.ok    = (page >= base_page) && (diff < PAGE_BITS'(TABLE_FRAMES));
        r.frame = diff[FRAME_BITS-1:0];
        return r;
    endfunction

endpackage

### hw/rtl/ptmi_walker.sv
// ----------------------------------------------------------------------------
// Page table walker
// Holds the table store and the frame allocator, walks the four levels of
// one request, allocates and clears missing tables, and writes the leaf.
// ----------------------------------------------------------------------------
module ptmi_walker
    import ptmi_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  ptmi_cfg_t       cfg,
    input  logic            start,
    input  ptmi_item_t      item,
    input  logic            out_free,
    output ptmi_wk_status_t wk_status,
    output ptmi_result_t    result
);

    ptmi_state_t state_reg, state_next;

    logic [STORE_BITS-1:0] cnt_reg;
    logic [ADDR_BITS-1:0]  next_frame_reg;
    logic [1:0]            level_reg;
    logic [1:0]            created_reg;
    logic [1:0]            status_reg;

    logic [PAGE_BITS-1:0]  va_page_reg;
    logic [PAGE_BITS-1:0]  pa_page_reg;
    logic [7:0]            flags_reg;
    logic [PAGE_BITS-1:0]  tbl_reg;
    logic [PAGE_BITS-1:0]  nf_reg;
    logic [STORE_BITS-1:0] slot_reg;
    logic [ADDR_BITS-1:0]  leaf_addr_reg;
    logic [ADDR_BITS-1:0]  leaf_val_reg;
    logic [ADDR_BITS-1:0]  rd_data_reg;

    logic [ADDR_BITS-1:0]  store_mem [0:STORE_DEPTH-1];

    logic                  mem_we;
    logic [STORE_BITS-1:0] mem_waddr;
    logic [ADDR_BITS-1:0]  mem_wdata;
    logic                  mem_re;

    logic [INDEX_BITS-1:0] idx;
    ptmi_win_t             win_tbl;
    ptmi_win_t             win_nf;
    logic                  exhausted;
    logic                  sweep_row_end;
    logic                  sweep_all_end;
    logic [ADDR_BITS-1:0]  leaf_value;
    logic [PAGE_BITS-1:0]  base_page;

    assign base_page = cfg.store_window_base[ADDR_BITS-1:12];

    always_comb
    begin
        case (level_reg)
            2'd0:    idx = va_page_reg[35:27];
            2'd1:    idx = va_page_reg[26:18];
            2'd2:    idx = va_page_reg[17:9];
            default: idx = va_page_reg[8:0];
        endcase
    end

    assign win_tbl       = window_check(tbl_reg, base_page);
    assign win_nf        = window_check(next_frame_reg[ADDR_BITS-1:12], base_page);
    assign exhausted     = ({1'b0, next_frame_reg} + 49'h1000) >= {1'b0, cfg.memory_end};
    assign sweep_row_end = (cnt_reg[INDEX_BITS-1:0] == {INDEX_BITS{1'b1}});
    assign sweep_all_end = (cnt_reg == STORE_BITS'(STORE_DEPTH - 1));
    // Bits 11..8 of a leaf entry stay clear; the present bit is always set.
    assign leaf_value    = {pa_page_reg, 4'b0000, flags_reg | 8'h01};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            WK_CLEAR:   if (sweep_all_end) state_next = WK_IDLE;
            WK_IDLE:    if (start) state_next = WK_CHECK;
            WK_CHECK:
            begin
                if (!win_tbl.ok)
                    state_next = WK_DONE;
                else if (level_reg == 2'd3)
                    state_next = WK_LEAF;
                else
                    state_next = WK_READ;
            end
            WK_READ:    state_next = WK_EVAL;
            WK_EVAL:    state_next = rd_data_reg[0] ? WK_CHECK : WK_LOAD;
            WK_LOAD:    state_next = WK_EXHAUST;
            WK_EXHAUST: state_next = exhausted ? WK_DONE : WK_WINDOW;
            WK_WINDOW:  state_next = win_nf.ok ? WK_ZERO : WK_DONE;
            WK_ZERO:    if (sweep_row_end) state_next = WK_LINK;
            WK_LINK:    state_next = WK_CHECK;
            WK_LEAF:    state_next = WK_DONE;
            WK_DONE:    if (out_free) state_next = WK_IDLE;
            default:    state_next = WK_CLEAR;
        endcase
    end

    // Outputs and memory controls.
    always_comb
    begin
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        wk_status.ready = 1'b0;
        wk_status.done  = 1'b0;
        case (state_reg)
            WK_CLEAR, WK_ZERO:
            begin
                mem_we = 1'b1;
            end
            WK_IDLE:  wk_status.ready = 1'b1;
            WK_READ:  mem_re = 1'b1;
            WK_LINK:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata = {nf_reg, 10'b0, 2'b11};
            end
            WK_LEAF:
            begin
                mem_we    = 1'b1;
                mem_waddr = slot_reg;
                mem_wdata = leaf_value;
            end
            WK_DONE:  wk_status.done = out_free;
            default:  mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= store_mem[slot_reg];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= WK_CLEAR;
            cnt_reg        <= '0;
            next_frame_reg <= '0;
            level_reg      <= '0;
            created_reg    <= '0;
            status_reg     <= STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                WK_CLEAR, WK_ZERO: cnt_reg <= cnt_reg + 1'b1;
                WK_IDLE:
                begin
                    level_reg   <= '0;
                    created_reg <= '0;
                    status_reg  <= STATUS_OK;
                end
                WK_CHECK:
                begin
                    if (!win_tbl.ok)
                        status_reg <= STATUS_OUTSIDE;
                end
                WK_EVAL:
                begin
                    if (rd_data_reg[0])
                        level_reg <= level_reg + 1'b1;
                end
                WK_LOAD:
                begin
                    // The allocator picks up its start address on first use.
                    if (next_frame_reg == '0)
                        next_frame_reg <= cfg.first_free_frame;
                end
                WK_EXHAUST:
                begin
                    if (exhausted)
                        status_reg <= STATUS_NO_FRAMES;
                end
                WK_WINDOW:
                begin
                    if (win_nf.ok)
                    begin
                        next_frame_reg <= next_frame_reg + 48'h1000;
                        cnt_reg        <= {win_nf.frame, {INDEX_BITS{1'b0}}};
                    end
                    else
                        status_reg <= STATUS_OUTSIDE;
                end
                WK_LINK:
                begin
                    created_reg <= created_reg + 1'b1;
                    level_reg   <= level_reg + 1'b1;
                end
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Request payload and walk pointers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            WK_IDLE:
            begin
                va_page_reg   <= item.virtual_address[ADDR_BITS-1:12];
                pa_page_reg   <= item.physical_address[ADDR_BITS-1:12];
                flags_reg     <= item.flags;
                tbl_reg       <= cfg.root_table_address[ADDR_BITS-1:12];
                leaf_addr_reg <= '0;
                leaf_val_reg  <= '0;
            end
            WK_CHECK:  slot_reg <= {win_tbl.frame, idx};
            WK_EVAL:   tbl_reg  <= rd_data_reg[ADDR_BITS-1:12];
            WK_WINDOW: nf_reg   <= next_frame_reg[ADDR_BITS-1:12];
            WK_LINK:   tbl_reg  <= nf_reg;
            WK_LEAF:
            begin
                leaf_addr_reg <= {tbl_reg, idx, 3'b000};
                leaf_val_reg  <= leaf_value;
            end
            default:   tbl_reg <= tbl_reg;
        endcase
    end

    assign result.status             = status_reg;
    assign result.tables_created     = created_reg;
    assign result.leaf_entry_address = leaf_addr_reg;
    assign result.leaf_entry_value   = leaf_val_reg;

endmodule

### hw/rtl/page_table_mapping_installer.sv
// Each new table is cleared one entry per cycle before it is linked into its parent.
// Flow: one item at a time; the walker takes no new item until it has finished
// the last one and handed its result to the output register.
// Reset: registers and allocator clear at once, then a clearing pass over all
// TABLE_FRAMES*512 (32768) store entries zeroes the table store before the first item.
// ----------------------------------------------------------------------------
// Page table mapping installer
// Installs one virtual-to-physical page mapping per item into a four-level
// page table held in an on-chip table store, with an APB register port.
// ----------------------------------------------------------------------------
`include "page_table_mapping_installer_defines.svh"

module page_table_mapping_installer
    import ptmi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // APB register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    // Request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // virtual_address[47:0], physical_address[95:48], flags[103:96]
    input  logic [103:0] s_axis_tdata,
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], tables_created[3:2], leaf_entry_address[51:4],
    // leaf_entry_value[99:52], zero[103:100]
    output logic [103:0] m_axis_tdata
);

    ptmi_cfg_t       cfg_reg;
    ptmi_item_t      item;
    ptmi_result_t    result;
    ptmi_result_t    out_reg;
    ptmi_wk_status_t wk_status;
    logic            m_valid_reg;
    logic            out_free;
    logic            start;
    logic            cfg_we;
    logic [1:0]      reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:3];
    assign cfg_we    = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            case (reg_index)
                REG_ROOT_TABLE:  cfg_reg.root_table_address <= pwdata[ADDR_BITS-1:0];
                REG_FIRST_FREE:  cfg_reg.first_free_frame   <= pwdata[ADDR_BITS-1:0];
                REG_MEMORY_END:  cfg_reg.memory_end         <= pwdata[ADDR_BITS-1:0];
                REG_WINDOW_BASE: cfg_reg.store_window_base  <= pwdata[ADDR_BITS-1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_ROOT_TABLE:  prdata = {16'b0, cfg_reg.root_table_address};
            REG_FIRST_FREE:  prdata = {16'b0, cfg_reg.first_free_frame};
            REG_MEMORY_END:  prdata = {16'b0, cfg_reg.memory_end};
            REG_WINDOW_BASE: prdata = {16'b0, cfg_reg.store_window_base};
            default:         prdata = '0;
        endcase
    end

    assign item          = s_axis_tdata;
    assign s_axis_tready = wk_status.ready;
    assign start         = s_axis_tvalid && wk_status.ready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    ptmi_walker u_walker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .start     (start),
        .item      (item),
        .out_free  (out_free),
        .wk_status (wk_status),
        .result    (result)
    );

    // Output register: a finished result waits here while the walker moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (wk_status.done)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wk_status.done)
            out_reg <= result;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, out_reg};

    `PTMI_ASSERT_IMP(a_done_into_free_slot, wk_status.done, out_free)
    `PTMI_ASSERT_NXT(a_busy_after_accept, start, !s_axis_tready)
    `PTMI_ASSERT_IMP(a_status_code_known, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
    `PTMI_ASSERT_IMP(a_error_has_no_leaf, m_axis_tvalid && (m_axis_tdata[1:0] != STATUS_OK),
                     m_axis_tdata[99:4] == '0)

endmodule

### dv/page_table_mapping_installer_test.sv
// ----------------------------------------------------------------------------
// Page table mapping installer testbench
// Drives mapping requests over the request stream and register writes over
// APB, predicts each result with a behavioral copy of the four-level table
// walk and its frame allocator or takes a known one, and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_table_mapping_installer_test
    import ptmi_pkg::*;
();

    localparam int          CYCLE_LIMIT     = 4000000;
    localparam int          SETTLE_CYCLES   = 40;
    localparam int          HOLD_OFF_CYCLES = 800;
    localparam logic [47:0] FRAME           = 48'h0000_0000_1000;
    localparam logic [47:0] MAX48           = 48'hffff_ffff_ffff;
    localparam logic [47:0] WIN_A           = 48'h0000_2000_0000;
    localparam logic [47:0] WIN_B           = WIN_A + 48'h0000_0003_f000;

    // Small pools of upper-level indexes so that random requests share tables.
    localparam logic [8:0] TOP_IDX [4] = '{9'd0, 9'd5, 9'd170, 9'd511};
    localparam logic [8:0] MID_IDX [3] = '{9'd0, 9'd85, 9'd511};
    localparam logic [8:0] LOW_IDX [2] = '{9'd0, 9'd511};

    typedef enum logic [1:0] {
        ROW_REQUEST,
        ROW_REQUEST_KNOWN,
        ROW_REGISTER
    } plan_kind_t;

    typedef struct {
        plan_kind_t   kind;
        logic [1:0]   reg_index;
        logic [47:0]  va_or_value;
        logic [47:0]  pa;
        logic [7:0]   flags;
        ptmi_result_t known;
    } plan_step_t;

    logic         clk;
    logic         rst_n         = 1'b0;
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [4:0]   paddr         = '0;
    logic [63:0]  pwdata        = '0;
    logic [63:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;

    // Behavioral copy of the table store, allocator and registers.
    bit [63:0]    page_tables [STORE_DEPTH];
    logic [47:0]  alloc_next    = '0;
    ptmi_cfg_t    reg_shadow    = '0;

    ptmi_result_t pending_installs [$];
    plan_step_t   directed_plan [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           recv_stall_pct = 0;
    logic         hold_active    = 1'b0;
    event         hold_off_ev;
    ptmi_result_t got_res;
    ptmi_result_t want_res;

    page_table_mapping_installer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Finds the store slot of an entry; returns 0 when the table lies outside
    // the window of TABLE_FRAMES frames.
    function automatic bit locate_entry(input logic [47:0] table_addr,
                                        input logic [8:0] idx,
                                        output int unsigned slot);
        logic [47:0] base_a;
        logic [47:0] page_a;
        logic [47:0] diff;
        base_a = {reg_shadow.store_window_base[47:12], 12'h000};
        page_a = {table_addr[47:12], 12'h000};
        diff   = page_a - base_a;
        slot   = 32'({diff[12 +: FRAME_BITS], idx});
        return (page_a >= base_a) && (diff[47:12] < TABLE_FRAMES);
    endfunction

    function automatic ptmi_result_t install_mapping(input ptmi_item_t it);
        ptmi_result_t r;
        logic [47:0]  table_addr;
        logic [47:0]  alloc_addr;
        logic [8:0]   idx;
        int unsigned  slot;
        int unsigned  first;
        int           lvl;
        bit           halted;
        r          = '0;
        halted     = 1'b0;
        table_addr = {reg_shadow.root_table_address[47:12], 12'h000};
        for (lvl = 0; lvl < 4 && !halted; lvl++)
        begin
            idx = it.virtual_address[39 - 9 * lvl +: 9];
            if (!locate_entry(table_addr, idx, slot))
            begin
                r.status = STATUS_OUTSIDE;
                halted   = 1'b1;
            end
            else if (lvl == 3)
            begin
                r.leaf_entry_value   = {it.physical_address[47:12], 12'h000}
                                       | 48'(it.flags | 8'h01);
                page_tables[slot]    = 64'(r.leaf_entry_value);
                r.leaf_entry_address = table_addr + 48'({idx, 3'b000});
            end
            else if (!page_tables[slot][0])
            begin
                // The allocator start is picked up lazily, only while empty.
                if (alloc_next == '0)
                    alloc_next = reg_shadow.first_free_frame;
                if ({1'b0, alloc_next} + 49'h1000 >= {1'b0, reg_shadow.memory_end})
                begin
                    r.status = STATUS_NO_FRAMES;
                    halted   = 1'b1;
                end
                else
                begin
                    alloc_addr = {alloc_next[47:12], 12'h000};
                    if (!locate_entry(alloc_addr, 9'd0, first))
                    begin
                        r.status = STATUS_OUTSIDE;
                        halted   = 1'b1;
                    end
                    else
                    begin
                        alloc_next = alloc_next + FRAME;
                        for (int e = 0; e < ENTRIES_PER_TABLE; e++)
                            page_tables[first + e] = '0;
                        page_tables[slot] = 64'(alloc_addr) | 64'h3;
                        r.tables_created  = r.tables_created + 2'd1;
                    end
                end
            end
            if (!halted && lvl < 3)
                table_addr = {page_tables[slot][47:12], 12'h000};
        end
        return r;
    endfunction

    function automatic ptmi_result_t make_result(input logic [1:0] st, input logic [1:0] cr,
                                                 input logic [47:0] la, input logic [47:0] lv);
        ptmi_result_t r;
        r.status             = st;
        r.tables_created     = cr;
        r.leaf_entry_address = la;
        r.leaf_entry_value   = lv;
        return r;
    endfunction

    function automatic void add_request(input logic [47:0] va, input logic [47:0] pa,
                                        input logic [7:0] fl);
        directed_plan.push_back('{ROW_REQUEST, REG_ROOT_TABLE, va, pa, fl, '0});
    endfunction

    function automatic void add_known(input logic [47:0] va, input logic [47:0] pa,
                                      input logic [7:0] fl, input ptmi_result_t res);
        directed_plan.push_back('{ROW_REQUEST_KNOWN, REG_ROOT_TABLE, va, pa, fl, res});
    endfunction

    function automatic void add_register(input logic [1:0] idx, input logic [47:0] value);
        directed_plan.push_back('{ROW_REGISTER, idx, value, '0, '0, '0});
    endfunction

    function automatic logic [47:0] random_va(input bit pooled);
        logic [47:0] va;
        va = 48'({$urandom, $urandom});
        if (pooled)
        begin
            va[47:39] = TOP_IDX[$urandom_range(3)];
            va[38:30] = MID_IDX[$urandom_range(2)];
            va[29:21] = LOW_IDX[$urandom_range(1)];
        end
        return va;
    endfunction

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Called at a clock edge; leaves tvalid high after the accepting edge.
    task automatic offer_item(input ptmi_item_t it, input bit known,
                              input ptmi_result_t known_res);
        ptmi_result_t predicted;
        s_axis_tdata  <= it;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = install_mapping(it);
        pending_installs.push_back(known ? known_res : predicted);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_installs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROOT_TABLE:  reg_shadow.root_table_address = value;
            REG_FIRST_FREE:  reg_shadow.first_free_frame   = value;
            REG_MEMORY_END:  reg_shadow.memory_end         = value;
            REG_WINDOW_BASE: reg_shadow.store_window_base  = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic run_random_phase(input int count, input int send_pct, input int recv_pct,
                                    input bit pooled, input int hold_at, input int drain_at);
        ptmi_item_t it;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            it.virtual_address  = random_va(pooled && ($urandom_range(99) < 85));
            it.physical_address = 48'({$urandom, $urandom});
            it.flags            = 8'($urandom_range(255));
            offer_item(it, 1'b0, '0);
            if (i == hold_at)
                -> hold_off_ev;
            if (i == drain_at)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending_installs.size() != 0)
                    @(posedge clk);
            end
            else if ($urandom_range(99) < send_pct)
            begin
                s_axis_tvalid <= 1'b0;
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(700, 100)) @(posedge clk);
                else
                    repeat ($urandom_range(12, 1)) @(posedge clk);
            end
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);

    // Long receiver hold-off, so that the block fills up and stalls its input.
    initial
    begin
        forever
        begin
            @(hold_off_ev);
            hold_active <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res = m_axis_tdata[99:0];
            if (pending_installs.size() == 0)
            begin
                $error("result item with no request outstanding: %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want_res = pending_installs.pop_front();
                check_field("status", 48'(want_res.status), 48'(got_res.status));
                check_field("tables_created", 48'(want_res.tables_created),
                            48'(got_res.tables_created));
                check_field("leaf_entry_address", want_res.leaf_entry_address,
                            got_res.leaf_entry_address);
                check_field("leaf_entry_value", want_res.leaf_entry_value,
                            got_res.leaf_entry_value);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("page_table_mapping_installer_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        ptmi_item_t it;

        // Everything zero after reset: the first allocation finds no room.
        add_known(48'h0, 48'h0, 8'h00, make_result(STATUS_NO_FRAMES, 2'd0, 48'h0, 48'h0));
        add_register(REG_WINDOW_BASE, WIN_A);
        add_register(REG_ROOT_TABLE, WIN_A);
        add_register(REG_FIRST_FREE, WIN_A + 48'h0004_0000);
        add_register(REG_MEMORY_END, MAX48);
        // The first new frame falls just past the window.
        add_known(48'h0, MAX48, 8'hff, make_result(STATUS_OUTSIDE, 2'd0, 48'h0, 48'h0));
        // Root table outside the window.
        add_register(REG_ROOT_TABLE, WIN_A + 48'h0004_0000);
        add_known(48'h1000, 48'h5555_5555_5555, 8'h55,
                  make_result(STATUS_OUTSIDE, 2'd0, 48'h0, 48'h0));
        // Window moved up so that the waiting frame is its second one; low address
        // bits are ignored.
        add_register(REG_WINDOW_BASE, WIN_B | 48'hfff);
        add_register(REG_ROOT_TABLE, WIN_B | 48'habc);
        add_known(48'h0, MAX48, 8'hff,
                  make_result(STATUS_OK, 2'd3, WIN_B + 48'h3000, 48'hffff_ffff_f0ff));
        add_known(MAX48, 48'h0, 8'h00,
                  make_result(STATUS_OK, 2'd3, WIN_B + 48'h6ff8, 48'h1));
        add_request(48'h1000, 48'h0123_4567_89ab, 8'ha5);
        add_request(48'h0, 48'h1234_5678_9abc, 8'h80);
        add_request(48'h0000_4000_0000, 48'haaaa_aaaa_aaaa, 8'h7e);
        // Memory ends after one more frame: the walk stops one table deep.
        add_register(REG_MEMORY_END, WIN_B + 48'hb000);
        add_known(48'h0280_0000_0000, 48'h3333_3333_3333, 8'h01,
                  make_result(STATUS_NO_FRAMES, 2'd1, 48'h0, 48'h0));
        add_register(REG_MEMORY_END, MAX48);
        add_request(48'h0280_0012_3456, 48'hcccc_cccc_cccc, 8'h3c);
        // A shifted window makes an existing link point outside it.
        add_register(REG_WINDOW_BASE, WIN_B + FRAME);
        add_register(REG_ROOT_TABLE, WIN_B + FRAME);
        add_request(48'hff80_0000_0000, 48'h0f0f_0f0f_0f0f, 8'hf0);
        add_register(REG_WINDOW_BASE, WIN_B);
        add_register(REG_ROOT_TABLE, WIN_B);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[n])
        begin
            if (directed_plan[n].kind == ROW_REGISTER)
            begin
                wait_idle();
                write_reg(directed_plan[n].reg_index, directed_plan[n].va_or_value);
            end
            else
            begin
                it.virtual_address  = directed_plan[n].va_or_value;
                it.physical_address = directed_plan[n].pa;
                it.flags            = directed_plan[n].flags;
                offer_item(it, directed_plan[n].kind == ROW_REQUEST_KNOWN,
                           directed_plan[n].known);
            end
        end

        // Shared prefixes under the first root until memory runs out.
        wait_idle();
        write_reg(REG_ROOT_TABLE, WIN_B);
        write_reg(REG_MEMORY_END, WIN_B + 40 * FRAME);
        write_reg(REG_FIRST_FREE, 48'({$urandom, $urandom}));
        run_random_phase(95, 0, 0, 1'b1, 20, -1);

        // A fresh root at the top of the window, allocating up to just below it.
        wait_idle();
        write_reg(REG_WINDOW_BASE, WIN_B | 48'($urandom_range(4095)));
        write_reg(REG_ROOT_TABLE, (WIN_B + 63 * FRAME) | 48'($urandom_range(4095)));
        write_reg(REG_MEMORY_END, WIN_B + 63 * FRAME);
        run_random_phase(95, 57, 0, 1'b1, -1, 45);

        // Window at the very top of the address space and no usable memory.
        wait_idle();
        write_reg(REG_WINDOW_BASE, MAX48);
        write_reg(REG_ROOT_TABLE, MAX48);
        write_reg(REG_FIRST_FREE, MAX48);
        write_reg(REG_MEMORY_END, 48'h0);
        run_random_phase(80, 0, 57, 1'b0, -1, -1);

        // Back to the first tree with unlimited memory.
        wait_idle();
        write_reg(REG_WINDOW_BASE, WIN_B);
        write_reg(REG_ROOT_TABLE, WIN_B);
        write_reg(REG_FIRST_FREE, 48'h0);
        write_reg(REG_MEMORY_END, MAX48);
        run_random_phase(95, 18, 18, 1'b1, -1, -1);

        wait_idle();
        if (pending_installs.size() != 0)
        begin
            $error("%0d results never arrived", pending_installs.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("page_table_mapping_installer_test OK");
        else
            $display("page_table_mapping_installer_test NOT OK");
        $finish;
    end

endmodule
